/* hw/rtl/mwmm_pkg.sv */
// shared constants for the moving window min/max/mean block
package mwmm_pkg;

    // default sizes
    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // window length register
    localparam int              LEN_W     = 7;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd8;

    // depth of the task queue between front and back
    localparam int TASK_DEPTH = 2;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;

endpackage

/* hw/rtl/mwmm_front.sv */
// front end: takes samples, tracks column fill, computes pair results, issues tasks
module mwmm_front #(
    parameter int MAX_WINDOW   = mwmm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = mwmm_pkg::SAMPLE_WIDTH_DEF,
    parameter int RING_DEPTH   = MAX_WINDOW + mwmm_pkg::TASK_DEPTH + 1,
    parameter int EFF_W        = $clog2(MAX_WINDOW + 1),
    parameter int PTR_W        = $clog2(RING_DEPTH),
    parameter int TASK_W       = 3 * SAMPLE_WIDTH + 2 * EFF_W + PTR_W + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mwmm_pkg::LEN_W-1:0]    window_len,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                          start_req,
    input  logic                          accept,
    output logic                          wr_en,
    output logic [PTR_W-1:0]              wr_addr,
    output logic [SAMPLE_WIDTH-1:0]       wr_data,
    output logic                          task_push,
    output logic [TASK_W-1:0]             task_data
);

    localparam int SW = SAMPLE_WIDTH;

    logic [EFF_W-1:0]        fill_reg, fill_next;
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic signed [SW-1:0]    prev_reg, prev_next;

    logic [EFF_W-1:0]        fill_cur;
    logic [EFF_W-1:0]        fill_new;
    logic [EFF_W-1:0]        eff;
    logic [EFF_W-1:0]        n_cnt;
    logic                    have_prev;
    logic signed [SW:0]      pair_sum;
    logic signed [SW:0]      pair_sum_adj;
    logic signed [SW:0]      diff_cp;
    logic signed [SW:0]      diff_pc;
    logic [SW-1:0]           pair_mean;
    logic [SW-1:0]           pair_abs;

    always_comb
    begin
        fill_cur  = start_req ? '0 : fill_reg;
        have_prev = (fill_cur != '0);
        fill_new  = (32'(fill_cur) == MAX_WINDOW) ? fill_cur : fill_cur + EFF_W'(1);

        // effective window, clamped to MAX_WINDOW
        if (32'(window_len) > MAX_WINDOW)
        begin
            eff = EFF_W'(MAX_WINDOW);
        end
        else
        begin
            eff = EFF_W'(window_len);
        end
        n_cnt = (eff < fill_new) ? eff : fill_new;

        // pair mean truncates toward zero
        pair_sum     = {sample[SW-1], sample} + {prev_reg[SW-1], prev_reg};
        pair_sum_adj = pair_sum + $signed({{SW{1'b0}}, pair_sum[SW]});
        diff_cp      = {sample[SW-1], sample} - {prev_reg[SW-1], prev_reg};
        diff_pc      = {prev_reg[SW-1], prev_reg} - {sample[SW-1], sample};
        pair_mean    = have_prev ? pair_sum_adj[SW:1] : '0;
        pair_abs     = have_prev ? (diff_cp[SW] ? diff_pc[SW-1:0] : diff_cp[SW-1:0]) : '0;

        fill_next   = fill_reg;
        wr_ptr_next = wr_ptr_reg;
        prev_next   = prev_reg;
        if (accept)
        begin
            fill_next   = fill_new;
            wr_ptr_next = (32'(wr_ptr_reg) == RING_DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
            prev_next   = sample;
        end

        wr_en     = accept;
        wr_addr   = wr_ptr_reg;
        wr_data   = sample;
        task_push = accept;
        task_data = {sample, n_cnt, eff, wr_ptr_reg, pair_mean, pair_abs, have_prev};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            wr_ptr_reg <= '0;
            prev_reg   <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            prev_reg   <= prev_next;
        end
    end

endmodule

/* hw/rtl/mwmm_fifo.sv */
// small task queue between front and back
module mwmm_fifo #(
    parameter int DEPTH = mwmm_pkg::TASK_DEPTH,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (32'(count_reg) == DEPTH);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* hw/rtl/mwmm_back.sv */
// back end: sample ring, window scan for min/max/sum, serial divide, result register
module mwmm_back #(
    parameter int MAX_WINDOW   = mwmm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = mwmm_pkg::SAMPLE_WIDTH_DEF,
    parameter int RING_DEPTH   = MAX_WINDOW + mwmm_pkg::TASK_DEPTH + 1,
    parameter int EFF_W        = $clog2(MAX_WINDOW + 1),
    parameter int PTR_W        = $clog2(RING_DEPTH),
    parameter int TASK_W       = 3 * SAMPLE_WIDTH + 2 * EFF_W + PTR_W + 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [PTR_W-1:0]         wr_addr,
    input  logic [SAMPLE_WIDTH-1:0]  wr_data,
    input  logic                     task_empty,
    input  logic [TASK_W-1:0]        task_data,
    output logic                     task_pop,
    input  logic                     pop,
    output logic                     empty,
    output logic [SAMPLE_WIDTH-1:0]  win_min,
    output logic [SAMPLE_WIDTH-1:0]  win_max,
    output logic [SAMPLE_WIDTH-1:0]  win_range,
    output logic [SAMPLE_WIDTH-1:0]  win_mean,
    output logic                     win_valid,
    output logic [SAMPLE_WIDTH-1:0]  pair_mean,
    output logic [SAMPLE_WIDTH-1:0]  pair_abs_diff,
    output logic                     pair_valid
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int SUM_W  = SW + $clog2(MAX_WINDOW + 1);
    localparam int DCNT_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_WB
    } state_t;

    // ring of recent samples
    logic [SW-1:0] ring_mem [RING_DEPTH];
    logic [SW-1:0] rd_data_reg;
    logic          rd_en;
    logic [PTR_W-1:0] rd_addr;

    // task fields
    logic [SW-1:0]    t_cur;
    logic [EFF_W-1:0] t_n;
    logic [EFF_W-1:0] t_eff;
    logic [PTR_W-1:0] t_ptr;
    logic [SW-1:0]    t_pmean;
    logic [SW-1:0]    t_pabs;
    logic             t_pvalid;

    state_t               state_reg, state_next;
    logic [EFF_W-1:0]     n_reg, n_next;
    logic [EFF_W-1:0]     eff_reg, eff_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [EFF_W-1:0]     issue_reg, issue_next;
    logic [EFF_W-1:0]     got_reg, got_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic signed [SW-1:0] min_reg, min_next;
    logic signed [SW-1:0] max_reg, max_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [EFF_W-1:0]     rem_reg, rem_next;
    logic [DCNT_W-1:0]    dcnt_reg, dcnt_next;
    logic                 neg_reg, neg_next;
    logic                 wv_reg, wv_next;
    logic [SW-1:0]        pm_reg, pm_next;
    logic [SW-1:0]        pa_reg, pa_next;
    logic                 pv_reg, pv_next;

    logic                 res_valid_reg, res_valid_next;
    logic [SW-1:0]        o_min_reg, o_min_next;
    logic [SW-1:0]        o_max_reg, o_max_next;
    logic [SW-1:0]        o_range_reg, o_range_next;
    logic [SW-1:0]        o_mean_reg, o_mean_next;
    logic                 o_wv_reg, o_wv_next;
    logic [SW-1:0]        o_pm_reg, o_pm_next;
    logic [SW-1:0]        o_pa_reg, o_pa_next;
    logic                 o_pv_reg, o_pv_next;

    logic signed [SW-1:0] rd_val;
    logic [EFF_W:0]       rem_sh;
    logic                 rem_ge;
    logic [SUM_W-1:0]     quo_signed;

    assign {t_cur, t_n, t_eff, t_ptr, t_pmean, t_pabs, t_pvalid} = task_data;

    assign rd_en   = (state_reg == S_SCAN) && (issue_reg != n_reg);
    assign rd_addr = ptr_reg;
    assign rd_val  = $signed(rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        eff_next       = eff_reg;
        ptr_next       = ptr_reg;
        issue_next     = issue_reg;
        got_next       = got_reg;
        rd_vld_next    = rd_en;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        neg_next       = neg_reg;
        wv_next        = wv_reg;
        pm_next        = pm_reg;
        pa_next        = pa_reg;
        pv_next        = pv_reg;
        res_valid_next = res_valid_reg;
        o_min_next     = o_min_reg;
        o_max_next     = o_max_reg;
        o_range_next   = o_range_reg;
        o_mean_next    = o_mean_reg;
        o_wv_next      = o_wv_reg;
        o_pm_next      = o_pm_reg;
        o_pa_next      = o_pa_reg;
        o_pv_next      = o_pv_reg;
        task_pop       = 1'b0;

        rem_sh     = {rem_reg, quo_reg[SUM_W-1]};
        rem_ge     = (rem_sh >= {1'b0, eff_reg});
        quo_signed = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;

        if (res_valid_reg && pop)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!task_empty)
                begin
                    task_pop   = 1'b1;
                    n_next     = t_n;
                    eff_next   = t_eff;
                    ptr_next   = t_ptr;
                    issue_next = '0;
                    got_next   = '0;
                    min_next   = $signed(t_cur);
                    max_next   = $signed(t_cur);
                    sum_next   = '0;
                    quo_next   = '0;
                    wv_next    = (t_eff != '0);
                    pm_next    = t_pmean;
                    pa_next    = t_pabs;
                    pv_next    = t_pvalid;
                    state_next = (t_eff != '0) ? S_SCAN : S_WB;
                end
            end

            S_SCAN:
            begin
                // one read issued and one sample folded per cycle, newest first
                if (rd_en)
                begin
                    issue_next = issue_reg + EFF_W'(1);
                    ptr_next   = (ptr_reg == '0) ? PTR_W'(RING_DEPTH - 1)
                                                 : ptr_reg - PTR_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (rd_val < min_reg)
                    begin
                        min_next = rd_val;
                    end
                    if (rd_val > max_reg)
                    begin
                        max_next = rd_val;
                    end
                    sum_next = sum_reg + {{(SUM_W-SW){rd_data_reg[SW-1]}}, rd_data_reg};
                    got_next = got_reg + EFF_W'(1);
                    if (got_reg + EFF_W'(1) == n_reg)
                    begin
                        state_next = S_PREP;
                    end
                end
            end

            S_PREP:
            begin
                neg_next   = sum_reg[SUM_W-1];
                quo_next   = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                // restoring divide of the magnitude, one quotient bit per cycle
                rem_next  = rem_ge ? EFF_W'(rem_sh - {1'b0, eff_reg}) : rem_sh[EFF_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], rem_ge};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (32'(dcnt_reg) == SUM_W - 1)
                begin
                    state_next = S_WB;
                end
            end

            S_WB:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_valid_next = 1'b1;
                    o_min_next     = wv_reg ? min_reg : '0;
                    o_max_next     = wv_reg ? max_reg : '0;
                    o_range_next   = wv_reg ? (max_reg - min_reg) : '0;
                    o_mean_next    = wv_reg ? quo_signed[SW-1:0] : '0;
                    o_wv_next      = wv_reg;
                    o_pm_next      = pm_reg;
                    o_pa_next      = pa_reg;
                    o_pv_next      = pv_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            eff_reg       <= '0;
            ptr_reg       <= '0;
            issue_reg     <= '0;
            got_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            min_reg       <= '0;
            max_reg       <= '0;
            sum_reg       <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            dcnt_reg      <= '0;
            neg_reg       <= 1'b0;
            wv_reg        <= 1'b0;
            pm_reg        <= '0;
            pa_reg        <= '0;
            pv_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
            o_min_reg     <= '0;
            o_max_reg     <= '0;
            o_range_reg   <= '0;
            o_mean_reg    <= '0;
            o_wv_reg      <= 1'b0;
            o_pm_reg      <= '0;
            o_pa_reg      <= '0;
            o_pv_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            eff_reg       <= eff_next;
            ptr_reg       <= ptr_next;
            issue_reg     <= issue_next;
            got_reg       <= got_next;
            rd_vld_reg    <= rd_vld_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            dcnt_reg      <= dcnt_next;
            neg_reg       <= neg_next;
            wv_reg        <= wv_next;
            pm_reg        <= pm_next;
            pa_reg        <= pa_next;
            pv_reg        <= pv_next;
            res_valid_reg <= res_valid_next;
            o_min_reg     <= o_min_next;
            o_max_reg     <= o_max_next;
            o_range_reg   <= o_range_next;
            o_mean_reg    <= o_mean_next;
            o_wv_reg      <= o_wv_next;
            o_pm_reg      <= o_pm_next;
            o_pa_reg      <= o_pa_next;
            o_pv_reg      <= o_pv_next;
        end
    end

    assign empty         = !res_valid_reg;
    assign win_min       = o_min_reg;
    assign win_max       = o_max_reg;
    assign win_range     = o_range_reg;
    assign win_mean      = o_mean_reg;
    assign win_valid     = o_wv_reg;
    assign pair_mean     = o_pm_reg;
    assign pair_abs_diff = o_pa_reg;
    assign pair_valid    = o_pv_reg;

endmodule

/* hw/rtl/moving_window_min_max_mean.sv */
// top level of the moving window min/max/mean block
//
//   channel   | handshake            | beat
//   ----------+----------------------+-----------------------------------------
//   input     | push / full          | sample, start_req
//   result    | pop / empty          | win_min/max/range/mean/valid, pair_*
//   config    | psel/penable/pready  | window_len at byte address 0
//
// the front takes one beat per cycle while the two-entry task queue has room
// the back takes a new item only once the last is written back: it reads the window
// samples from the ring's single read port one per cycle, then runs a one-bit-per-cycle
// divide over SUM_W = SAMPLE_WIDTH + clog2(MAX_WINDOW+1) bits
// rst_n clears fill count, ring pointer and all control; the ring itself is not cleared
// a result that is not popped holds the back, and a full task queue raises full
module moving_window_min_max_mean #(
    parameter int MAX_WINDOW   = mwmm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = mwmm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mwmm_pkg::PADDR_W-1:0]        paddr,
    input  logic [mwmm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mwmm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,

    // input side
    input  logic                                push,
    output logic                                full,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample,
    input  logic                                start_req,

    // result side
    input  logic                                pop,
    output logic                                empty,
    output logic signed [SAMPLE_WIDTH-1:0]      win_min,
    output logic signed [SAMPLE_WIDTH-1:0]      win_max,
    output logic [SAMPLE_WIDTH-1:0]             win_range,
    output logic signed [SAMPLE_WIDTH-1:0]      win_mean,
    output logic                                win_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      pair_mean,
    output logic [SAMPLE_WIDTH-1:0]             pair_abs_diff,
    output logic                                pair_valid
);

    // ring holds the longest window plus every sample that can be queued behind it
    localparam int RING_DEPTH = MAX_WINDOW + mwmm_pkg::TASK_DEPTH + 1;
    localparam int EFF_W      = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int TASK_W     = 3 * SAMPLE_WIDTH + 2 * EFF_W + PTR_W + 1;

    // window length register
    logic [mwmm_pkg::LEN_W-1:0]     window_len_reg;
    logic [mwmm_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;

    // front to queue to back
    logic                      in_accept;
    logic                      wr_en;
    logic [PTR_W-1:0]          wr_addr;
    logic [SAMPLE_WIDTH-1:0]   wr_data;
    logic                      task_push;
    logic [TASK_W-1:0]         task_in;
    logic [TASK_W-1:0]         task_out;
    logic                      task_empty;
    logic                      task_pop;

    logic [SAMPLE_WIDTH-1:0]   win_min_u;
    logic [SAMPLE_WIDTH-1:0]   win_max_u;
    logic [SAMPLE_WIDTH-1:0]   win_mean_u;
    logic [SAMPLE_WIDTH-1:0]   pair_mean_u;

    // register access: no wait states, word index above the byte offset
    assign pready    = 1'b1;
    assign reg_idx   = paddr[mwmm_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready
                       && (reg_idx == mwmm_pkg::REG_WINDOW_LEN);

    always_comb
    begin
        prdata = '0;
        if (reg_idx == mwmm_pkg::REG_WINDOW_LEN)
        begin
            prdata = mwmm_pkg::APB_DATA_W'(window_len_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= mwmm_pkg::LEN_RESET;
        end
        else if (cfg_write)
        begin
            window_len_reg <= pwdata[mwmm_pkg::LEN_W-1:0];
        end
    end

    // a beat is taken whenever the task queue has room
    assign in_accept = push && !full;

    mwmm_front #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .RING_DEPTH   (RING_DEPTH),
        .EFF_W        (EFF_W),
        .PTR_W        (PTR_W),
        .TASK_W       (TASK_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .window_len (window_len_reg),
        .sample     (sample),
        .start_req  (start_req),
        .accept     (in_accept),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .task_push  (task_push),
        .task_data  (task_in)
    );

    mwmm_fifo #(
        .DEPTH (mwmm_pkg::TASK_DEPTH),
        .WIDTH (TASK_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (task_push),
        .push_data (task_in),
        .full      (full),
        .pop       (task_pop),
        .pop_data  (task_out),
        .empty     (task_empty)
    );

    mwmm_back #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .RING_DEPTH   (RING_DEPTH),
        .EFF_W        (EFF_W),
        .PTR_W        (PTR_W),
        .TASK_W       (TASK_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .task_empty    (task_empty),
        .task_data     (task_out),
        .task_pop      (task_pop),
        .pop           (pop),
        .empty         (empty),
        .win_min       (win_min_u),
        .win_max       (win_max_u),
        .win_range     (win_range),
        .win_mean      (win_mean_u),
        .win_valid     (win_valid),
        .pair_mean     (pair_mean_u),
        .pair_abs_diff (pair_abs_diff),
        .pair_valid    (pair_valid)
    );

    assign win_min   = $signed(win_min_u);
    assign win_max   = $signed(win_max_u);
    assign win_mean  = $signed(win_mean_u);
    assign pair_mean = $signed(pair_mean_u);

`ifndef SYNTHESIS
    // a window result never has its minimum above its maximum
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && win_valid) |-> (win_min <= win_max))
        else $error("window minimum above maximum");

    // range is the difference of the reported extremes
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && win_valid) |-> (win_range == SAMPLE_WIDTH'(win_max - win_min)))
        else $error("window range inconsistent with min and max");

    // invalid window fields read as zero
    a_win_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !win_valid) |-> (win_min == '0 && win_max == '0
                                    && win_range == '0 && win_mean == '0))
        else $error("invalid window result not zero");

    // invalid pair fields read as zero
    a_pair_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pair_valid) |-> (pair_mean == '0 && pair_abs_diff == '0))
        else $error("invalid pair result not zero");
`endif

endmodule

/* test/moving_window_min_max_mean_tb.sv */
// self-checking testbench for the moving window min/max/mean block
module moving_window_min_max_mean_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mwmm_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEF;
    localparam int MW = MAX_WINDOW_DEF;

    // byte address of the window length register
    localparam logic [PADDR_W-1:0] LEN_ADDR = {REG_WINDOW_LEN, 2'b00};

    // long receiver hold-off: starts once this many beats went in
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 600;

    // idle regimes: sender 25 / receiver 75, then swapped, then none
    localparam int REGIME_SEND_LIGHT = 1;
    localparam int REGIME_SEND_HEAVY = 2;
    localparam int REGIME_NO_IDLE    = 3;

    typedef struct {
        logic [SW-1:0] smp;
        logic          st;
    } sample_beat_t;

    typedef struct {
        logic [SW-1:0] win_min;
        logic [SW-1:0] win_max;
        logic [SW-1:0] win_range;
        logic [SW-1:0] win_mean;
        logic          win_valid;
        logic [SW-1:0] pair_mean;
        logic [SW-1:0] pair_abs_diff;
        logic          pair_valid;
    } stats_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    // block ports, all known from time zero
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_W-1:0]    paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  push      = 1'b0;
    logic                  full;
    logic signed [SW-1:0]  sample    = '0;
    logic                  start_req = 1'b0;

    logic                  pop = 1'b0;
    logic                  empty;
    logic signed [SW-1:0]  win_min;
    logic signed [SW-1:0]  win_max;
    logic [SW-1:0]         win_range;
    logic signed [SW-1:0]  win_mean;
    logic                  win_valid;
    logic signed [SW-1:0]  pair_mean;
    logic [SW-1:0]         pair_abs_diff;
    logic                  pair_valid;

    moving_window_min_max_mean dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .sample        (sample),
        .start_req     (start_req),
        .pop           (pop),
        .empty         (empty),
        .win_min       (win_min),
        .win_max       (win_max),
        .win_range     (win_range),
        .win_mean      (win_mean),
        .win_valid     (win_valid),
        .pair_mean     (pair_mean),
        .pair_abs_diff (pair_abs_diff),
        .pair_valid    (pair_valid)
    );

    // samples waiting to be pushed, filled by the sequencing block
    sample_beat_t sample_q[$];
    // window stats still owed by the block, oldest first
    stats_t       stats_q[$];

    int fails         = 0;
    int beats_in      = 0;
    int send_idle_pct = 25;
    int recv_idle_pct = 75;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    sample_beat_t drv_beat;
    stats_t       want_beat;

    // ------------------------------------------------------------------
    // predictor state: its own ring, pointer, column fill and window length
    // ------------------------------------------------------------------
    logic signed [SW-1:0] ring [MW];
    logic [5:0]           ring_pos = '0;
    int                   col_fill = 0;
    logic [LEN_W-1:0]     cfg_len  = LEN_RESET;

    // stats for one accepted sample; advances the predictor state
    function automatic stats_t next_stats(input logic signed [SW-1:0] cur, input logic st);
        stats_t     r;
        longint     v;
        longint     prv;
        longint     mn;
        longint     mx;
        longint     sum;
        longint     q;
        int         eff;
        int         span;
        logic [5:0] idx;
        logic       have_prev;

        // a start request opens a new column; the ring pointer keeps running
        if (st)
            col_fill = 0;
        have_prev = (col_fill > 0);
        prv = 0;
        if (have_prev)
        begin
            idx = ring_pos - 6'd1;
            prv = ring[idx];
        end

        ring[ring_pos] = cur;
        ring_pos = ring_pos + 6'd1;
        if (col_fill < MW)
            col_fill++;

        // lengths above the ring depth act as the ring depth, divisor too
        eff = (cfg_len > MW) ? MW : int'(cfg_len);

        if (eff >= 1)
        begin
            span = (eff < col_fill) ? eff : col_fill;
            mn   = cur;
            mx   = cur;
            sum  = 0;
            for (int k = 0; k < span; k++)
            begin
                idx = ring_pos - 6'(k + 1);
                v   = ring[idx];
                if (v < mn)
                    mn = v;
                if (v > mx)
                    mx = v;
                sum += v;
            end
            // divide by the full window, not by the samples present
            q = sum / longint'(eff);
            r.win_min   = mn[SW-1:0];
            r.win_max   = mx[SW-1:0];
            v           = mx - mn;
            r.win_range = v[SW-1:0];
            r.win_mean  = q[SW-1:0];
            r.win_valid = 1'b1;
        end
        else
        begin
            // zero length: window outputs are all zero and flagged invalid
            r.win_min   = '0;
            r.win_max   = '0;
            r.win_range = '0;
            r.win_mean  = '0;
            r.win_valid = 1'b0;
        end

        if (have_prev)
        begin
            // pair mean truncates toward zero, diff is a plain magnitude
            v = cur;
            q = (prv + v) / 2;
            r.pair_mean = q[SW-1:0];
            q = v - prv;
            if (q < 0)
                q = -q;
            r.pair_abs_diff = q[SW-1:0];
            r.pair_valid    = 1'b1;
        end
        else
        begin
            // first sample of a column has no pair
            r.pair_mean     = '0;
            r.pair_abs_diff = '0;
            r.pair_valid    = 1'b0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [SW-1:0] want,
                                        input logic [SW-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fails++;
        end
    endfunction

    // ------------------------------------------------------------------
    // input driver: pops pending samples, holds a beat while full is high
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push      <= 1'b0;
            sample    <= '0;
            start_req <= 1'b0;
        end
        else
        begin
            // beat taken at this edge: predict its stats now
            if (push && !full)
            begin
                stats_q.push_back(next_stats(sample, start_req));
                beats_in <= beats_in + 1;
            end

            if (push && full)
            begin
                // stalled: keep the same beat on the port
            end
            else if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drv_beat  = sample_q.pop_front();
                push      <= 1'b1;
                sample    <= drv_beat.smp;
                start_req <= drv_beat.st;
            end
            else
                push <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // long receiver hold-off, counted in its own process
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && beats_in >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // result monitor: checks each popped beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (stats_q.size() == 0)
                begin
                    $error("result beat with no prediction waiting");
                    fails++;
                end
                else
                begin
                    want_beat = stats_q.pop_front();
                    check_field("win_min", want_beat.win_min, win_min);
                    check_field("win_max", want_beat.win_max, win_max);
                    check_field("win_range", want_beat.win_range, win_range);
                    check_field("win_mean", want_beat.win_mean, win_mean);
                    check_field("win_valid", SW'(want_beat.win_valid), SW'(win_valid));
                    check_field("pair_mean", want_beat.pair_mean, pair_mean);
                    check_field("pair_abs_diff", want_beat.pair_abs_diff, pair_abs_diff);
                    check_field("pair_valid", SW'(want_beat.pair_valid), SW'(pair_valid));
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // sequencing helpers; all queue and knob updates happen at negedge
    // ------------------------------------------------------------------

    // sender pause: nothing pending, nothing on the port, nothing owed
    task automatic settle();
        @(negedge clk);
        while (sample_q.size() != 0 || push || stats_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LEN_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write the window length, read it back, then track it in the predictor
    task automatic set_len(input logic [APB_DATA_W-1:0] wdata);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, wdata, rd);
        apb_access(1'b0, '0, rd);
        if (rd[LEN_W-1:0] !== wdata[LEN_W-1:0])
        begin
            $error("window_len readback: expected %h, got %h", wdata[LEN_W-1:0],
                   rd[LEN_W-1:0]);
            fails++;
        end
        cfg_len = wdata[LEN_W-1:0];
        @(negedge clk);
    endtask

    task automatic set_regime(input int regime);
        case (regime)
            REGIME_SEND_LIGHT:
            begin
                send_idle_pct = 25;
                recv_idle_pct = 75;
            end
            REGIME_SEND_HEAVY:
            begin
                send_idle_pct = 75;
                recv_idle_pct = 25;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic add(input logic [SW-1:0] s, input logic st);
        sample_beat_t b;
        b.smp = s;
        b.st  = st;
        sample_q.push_back(b);
    endtask

    // mix of extremes, small integers (lots of ties), tiny fractions, full range
    function automatic logic [SW-1:0] rand_sample();
        logic [SW-1:0] u;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0:       return {1'b0, {(SW-1){1'b1}}};
                    1:       return {1'b1, {(SW-1){1'b0}}};
                    2:       return '1;
                    default: return '0;
                endcase
            end
            1, 2, 3:
            begin
                u = $urandom_range(16);
                return (u - 32'd8) << 16;
            end
            4, 5:
            begin
                u = $urandom_range(511);
                return u - 32'd256;
            end
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    int                    phase_cnt  [8] = '{80, 45, 80, 40, 50, 45, 80, 50};
    int                    phase_odds [8] = '{200, 12, 200, 10, 15, 8, 200, 20};
    logic [APB_DATA_W-1:0] phase_len  [8];

    initial
    begin
        // window lengths: full ring, one, above ring, zero, odd, two,
        // above ring with junk in the upper data bits, and one random
        phase_len = '{32'd64, 32'd1, 32'd127, 32'd0, 32'd17, 32'd2, 32'hFFFF_FFE4,
                      32'($urandom_range(127))};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_regime(REGIME_SEND_LIGHT);

        // reset window length of 8: extremes, wide pair diffs, odd negative sums
        add(32'h0000_0000, 1'b1);
        add(32'h7FFF_FFFF, 1'b0);
        add(32'h8000_0000, 1'b0);
        add(32'h7FFF_FFFF, 1'b0);
        add(32'hFFFF_FFFF, 1'b0);
        add(32'h0000_0000, 1'b0);
        add(32'hFFFF_FFFD, 1'b0);
        add(32'h8000_0000, 1'b0);
        add(32'h8000_0000, 1'b0);
        add(32'h8000_0000, 1'b0);

        // short window, new columns mid-stream and back to back
        settle();
        set_len(32'd3);
        add(32'h0005_0000, 1'b1);
        add(32'hFFFF_FFF9, 1'b0);
        add(32'h0000_0001, 1'b0);
        add(32'h7FFF_FFFF, 1'b1);
        add(32'hFFFF_FFFF, 1'b1);
        add(32'h0001_0000, 1'b0);
        add(32'h0000_8000, 1'b0);

        // zero window length: window outputs invalid, pairs still live
        settle();
        set_len(32'd0);
        add(32'h0000_007B, 1'b0);
        add(32'hFFFF_FFFB, 1'b1);
        add(32'h7FFF_FFFF, 1'b0);
        add(32'h8000_0000, 1'b0);

        // random phases, one window length each; long windows get long columns
        for (int p = 0; p < 8; p++)
        begin
            settle();
            set_len(phase_len[p]);
            set_regime(p < 3 ? REGIME_SEND_LIGHT :
                       p < 6 ? REGIME_SEND_HEAVY : REGIME_NO_IDLE);
            for (int i = 0; i < phase_cnt[p]; i++)
                add(rand_sample(),
                    (i == 0 && phase_odds[p] >= 200) ||
                    ($urandom_range(phase_odds[p] - 1) == 0));
        end

        // drain, then give the back end time to show any stray beat
        settle();
        repeat (150) @(posedge clk);
        if (fails == 0)
            $display("moving_window_min_max_mean_tb OK");
        else
            $display("moving_window_min_max_mean_tb NOT OK");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #1_000_000;
        $display("moving_window_min_max_mean_tb NOT OK");
        $finish;
    end

endmodule
